// File: hdl/source_token_scanner_macros.svh
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, checking switched off while reset is high
`define STS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking switched off while reset is high
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sts_pkg.sv
package sts_pkg;

  // input item modes
  localparam logic [1:0] MODE_CHAR    = 2'd0;
  localparam logic [1:0] MODE_EOL     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // token kinds as they leave the block
  typedef enum logic [4:0] {
    KIND_ERR, KIND_ID, KIND_WHILE, KIND_IF, KIND_ELSE, KIND_READ, KIND_WRITE,
    KIND_INT, KIND_REAL, KIND_INT_LIT, KIND_REAL_LIT, KIND_PLUS, KIND_MINUS,
    KIND_TIMES, KIND_DIV, KIND_ASSIGN, KIND_LESS, KIND_EQUAL, KIND_UNEQUAL,
    KIND_LPAREN, KIND_RPAREN, KIND_SEMI, KIND_LBRACE, KIND_RBRACE,
    KIND_LBRACKET, KIND_RBRACKET
  } token_kind_t;

  // one token as it leaves the block
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [7:0]  start_column;
    logic [7:0]  token_length;
    logic [15:0] error_count;
    logic        last;
  } token_t;

  // tokens produced by one accepted item, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // output queue status seen by the input side
  typedef struct packed {
    logic [1:0] fill;
    logic       room;
  } queue_status_t;

endpackage

// File: hdl/sts_in_if.sv
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] character;

  modport source (output valid, output mode, output character, input ready);
  modport sink (input valid, input mode, input character, output ready);
endinterface

// File: hdl/sts_out_if.sv
interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] line_number;
  logic [7:0]  start_column;
  logic [7:0]  token_length;
  logic [15:0] error_count;
  logic        last;

  modport source (
    output valid, output token_kind, output line_number, output start_column,
    output token_length, output error_count, output last, input ready
  );
  modport sink (
    input valid, input token_kind, input line_number, input start_column,
    input token_length, input error_count, input last, output ready
  );
endinterface

// File: hdl/sts_scan_core.sv
module sts_scan_core
  import sts_pkg::*;
#(
  parameter int LINE_MAX         = 256,
  parameter int LINE_NUMBER_BITS = 16,
  parameter int ERROR_COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [1:0] mode,
  input  logic [7:0] character,
  output push_t      push
);

  localparam int COL_BITS = $clog2(LINE_MAX);
  localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(LINE_MAX - 1);

  // keyword text, first character in the lowest byte, zero padded
  localparam logic [4:0][7:0] KW_WHILE = {"e", "l", "i", "h", "w"};
  localparam logic [4:0][7:0] KW_IF    = {8'h00, 8'h00, 8'h00, "f", "i"};
  localparam logic [4:0][7:0] KW_ELSE  = {8'h00, "e", "s", "l", "e"};
  localparam logic [4:0][7:0] KW_READ  = {8'h00, "d", "a", "e", "r"};
  localparam logic [4:0][7:0] KW_WRITE = {"e", "t", "i", "r", "w"};
  localparam logic [4:0][7:0] KW_INT   = {8'h00, 8'h00, "t", "n", "i"};
  localparam logic [4:0][7:0] KW_REAL  = {8'h00, "l", "a", "e", "r"};

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDENT, ST_NUM, ST_NUMERR, ST_SLASH, ST_LESS, ST_EQ,
    ST_COMMENT, ST_CSTAR
  } scan_state_t;

  function automatic logic [4:0] ident_kind(input logic [4:0][7:0] text,
                                            input logic [7:0] len,
                                            input logic uscore);
    logic [4:0] kind;
    kind = KIND_ID;
    if (uscore)                                  kind = KIND_ERR;
    else if (len == 8'd5 && text == KW_WHILE)    kind = KIND_WHILE;
    else if (len == 8'd2 && text == KW_IF)       kind = KIND_IF;
    else if (len == 8'd4 && text == KW_ELSE)     kind = KIND_ELSE;
    else if (len == 8'd4 && text == KW_READ)     kind = KIND_READ;
    else if (len == 8'd5 && text == KW_WRITE)    kind = KIND_WRITE;
    else if (len == 8'd3 && text == KW_INT)      kind = KIND_INT;
    else if (len == 8'd4 && text == KW_REAL)     kind = KIND_REAL;
    return kind;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] kind;
    case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_TIMES;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      ";":     kind = KIND_SEMI;
      "{":     kind = KIND_LBRACE;
      "}":     kind = KIND_RBRACE;
      "[":     kind = KIND_LBRACKET;
      "]":     kind = KIND_RBRACKET;
      default: kind = KIND_ERR;
    endcase
    return kind;
  endfunction

  // scanner state
  scan_state_t                 state, state_next;
  logic [LINE_NUMBER_BITS-1:0] line_count, line_next;
  logic [COL_BITS-1:0]         column, column_next;
  logic [COL_BITS-1:0]         token_start, start_next;
  logic [7:0]                  token_len, len_next;
  logic [1:0]                  dot_count, dots_next;
  logic                        uscore, uscore_next;
  logic [4:0][7:0]             kw_buf, kw_next;
  logic [ERROR_COUNT_BITS-1:0] error_total, errors_next;

  // per-item decode
  logic [7:0]                  ch;
  logic                        is_letter, is_digit, is_word;
  logic                        overlong;
  logic [LINE_NUMBER_BITS-1:0] line_inc;
  scan_state_t                 post_close;
  logic                        pend;
  logic [4:0]                  close_kind;
  logic                        close_fire, take_fire, fall, grow, start_token;
  scan_state_t                 take_state;
  logic [COL_BITS-1:0]         take_col;
  logic [LINE_NUMBER_BITS-1:0] take_line;
  logic [4:0]                  take_kind;
  logic [COL_BITS-1:0]         take_start;
  logic [7:0]                  take_len;
  logic [ERROR_COUNT_BITS-1:0] err_close, err_take;

  // case folding and character classes
  assign ch        = (character inside {["A":"Z"]}) ? character + 8'd32 : character;
  assign is_letter = ch inside {["a":"z"]};
  assign is_digit  = ch inside {["0":"9"]};
  assign is_word   = is_letter || is_digit || (ch == "_");

  assign overlong  = (mode == MODE_CHAR) && (column >= COL_LAST);
  assign line_inc  = (line_count == '1) ? line_count : line_count + 1'b1;

  // token held by the registered state, closed by a character that does not extend it or by a line end
  always_comb begin
    pend       = 1'b1;
    close_kind = KIND_ERR;
    post_close = ST_IDLE;
    case (state)
      ST_IDENT:   close_kind = ident_kind(kw_buf, token_len, uscore);
      ST_NUM: begin
        if (dot_count == 2'd0)      close_kind = KIND_INT_LIT;
        else if (dot_count == 2'd1) close_kind = KIND_REAL_LIT;
        else                        close_kind = KIND_ERR;
      end
      ST_NUMERR:  close_kind = KIND_ERR;
      ST_SLASH:   close_kind = KIND_DIV;
      ST_LESS:    close_kind = KIND_LESS;
      ST_EQ:      close_kind = KIND_ASSIGN;
      ST_COMMENT, ST_CSTAR: begin
        pend       = 1'b0;
        post_close = ST_COMMENT;
      end
      default:    pend = 1'b0;
    endcase
  end

  // next state and the at most two tokens of this beat
  always_comb begin
    state_next  = state;
    line_next   = line_count;
    column_next = column;
    start_next  = token_start;
    len_next    = token_len;
    dots_next   = dot_count;
    uscore_next = uscore;
    kw_next     = kw_buf;
    close_fire  = 1'b0;
    take_fire   = 1'b0;
    fall        = 1'b0;
    grow        = 1'b0;
    start_token = 1'b0;
    take_state  = state;
    take_col    = column;
    take_line   = line_count;
    take_kind   = KIND_ERR;
    take_start  = token_start;
    take_len    = 8'd1;
    if (fire) begin
      case (mode)
        MODE_RESTART: begin
          state_next  = ST_IDLE;
          line_next   = LINE_NUMBER_BITS'(1);
          column_next = '0;
          start_next  = '0;
          len_next    = '0;
          dots_next   = '0;
          uscore_next = 1'b0;
          kw_next     = '0;
        end
        MODE_EOL: begin
          close_fire  = pend;
          state_next  = post_close;
          line_next   = line_inc;
          column_next = '0;
        end
        MODE_CHAR: begin
          // full line: behave as a line end first
          if (overlong) begin
            close_fire = pend;
            take_state = post_close;
            take_line  = line_inc;
            take_col   = '0;
          end
          state_next = take_state;
          line_next  = take_line;
          case (take_state)
            ST_COMMENT: begin
              if (ch == "*") state_next = ST_CSTAR;
            end
            ST_CSTAR: begin
              if (ch == "/")      state_next = ST_IDLE;
              else if (ch != "*") state_next = ST_COMMENT;
            end
            ST_IDENT: begin
              if (is_word) begin
                grow        = 1'b1;
                uscore_next = (ch == "_");
              end else begin
                fall = 1'b1;
              end
            end
            ST_NUM: begin
              if (is_digit || ch == ".") begin
                grow = 1'b1;
                if (ch == "." && dot_count != 2'd2) dots_next = dot_count + 2'd1;
              end else if (is_letter || ch == "_") begin
                grow       = 1'b1;
                state_next = ST_NUMERR;
              end else begin
                fall = 1'b1;
              end
            end
            ST_NUMERR: begin
              if (is_word) grow = 1'b1;
              else         fall = 1'b1;
            end
            ST_SLASH: begin
              if (ch == "*") state_next = ST_COMMENT;
              else           fall = 1'b1;
            end
            ST_LESS: begin
              if (ch == ">") begin
                take_fire  = 1'b1;
                take_kind  = KIND_UNEQUAL;
                take_len   = 8'd2;
                state_next = ST_IDLE;
              end else begin
                fall = 1'b1;
              end
            end
            ST_EQ: begin
              if (ch == "=") begin
                take_fire  = 1'b1;
                take_kind  = KIND_EQUAL;
                take_len   = 8'd2;
                state_next = ST_IDLE;
              end else begin
                fall = 1'b1;
              end
            end
            default: fall = 1'b1;
          endcase

          // close the pending token and start on this character
          if (fall) begin
            close_fire = pend;
            state_next = ST_IDLE;
            take_start = take_col;
            if (is_letter) begin
              state_next  = ST_IDENT;
              start_token = 1'b1;
            end else if (is_digit) begin
              state_next  = ST_NUM;
              start_token = 1'b1;
            end else begin
              case (ch)
                "/": begin
                  state_next  = ST_SLASH;
                  start_token = 1'b1;
                end
                "<": begin
                  state_next  = ST_LESS;
                  start_token = 1'b1;
                end
                "=": begin
                  state_next  = ST_EQ;
                  start_token = 1'b1;
                end
                " ", 8'h09, 8'h00, 8'h0A: begin
                  // separators give nothing
                end
                default: begin
                  take_fire = 1'b1;
                  take_kind = single_kind(ch);
                end
              endcase
            end
          end

          if (grow) begin
            if (token_len < 8'd5) kw_next[token_len[2:0]] = ch;
            if (token_len != 8'd255) len_next = token_len + 8'd1;
          end
          if (start_token) begin
            start_next  = take_col;
            len_next    = 8'd1;
            dots_next   = '0;
            uscore_next = 1'b0;
            kw_next     = {32'h0, ch};
          end
          column_next = take_col + 1'b1;
        end
        default: begin
          // the none mode is ignored
        end
      endcase
    end
  end

  // running error count, saturating, counted token by token, cleared on restart
  always_comb begin
    err_close = error_total;
    if (close_fire && close_kind == KIND_ERR && error_total != '1)
      err_close = error_total + 1'b1;
    err_take = err_close;
    if (take_fire && take_kind == KIND_ERR && err_close != '1)
      err_take = err_close + 1'b1;
    errors_next = (fire && mode == MODE_RESTART) ? '0 : err_take;
  end

  // tokens handed to the output queue, closed token first
  always_comb begin
    token_t tok_close;
    token_t tok_take;
    tok_close.token_kind   = close_kind;
    tok_close.line_number  = 16'(line_count);
    tok_close.start_column = 8'(token_start);
    tok_close.token_length = token_len;
    tok_close.error_count  = 16'(err_close);
    tok_close.last         = !take_fire;
    tok_take.token_kind    = take_kind;
    tok_take.line_number   = 16'(take_line);
    tok_take.start_column  = 8'(take_start);
    tok_take.token_length  = take_len;
    tok_take.error_count   = 16'(err_take);
    tok_take.last          = 1'b1;
    push.count  = {1'b0, close_fire} + {1'b0, take_fire};
    push.first  = close_fire ? tok_close : tok_take;
    push.second = tok_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_count  <= LINE_NUMBER_BITS'(1);
      column      <= '0;
      token_start <= '0;
      token_len   <= '0;
      dot_count   <= '0;
      uscore      <= 1'b0;
      kw_buf      <= '0;
      error_total <= '0;
    end else begin
      state       <= state_next;
      line_count  <= line_next;
      column      <= column_next;
      token_start <= start_next;
      token_len   <= len_next;
      dot_count   <= dots_next;
      uscore      <= uscore_next;
      kw_buf      <= kw_next;
      error_total <= errors_next;
    end
  end

endmodule

// File: hdl/sts_out_queue.sv
module sts_out_queue
  import sts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  sts_out_if.source       tokens,
  output queue_status_t   status
);

  logic [1:0] fill;
  token_t     head, tail;
  logic       pop;

  assign pop = tokens.valid && tokens.ready;

  // room for a full pair once the head beat has gone
  assign status.fill = fill;
  assign status.room = (fill == 2'd0) || (fill == 2'd1 && tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill - {1'b0, pop} + push.count;
    end
  end

  // a push only lands in an empty or draining queue
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      head <= push.first;
      tail <= push.second;
    end else if (pop) begin
      head <= tail;
    end
  end

  assign tokens.valid        = (fill != 2'd0);
  assign tokens.token_kind   = head.token_kind;
  assign tokens.line_number  = head.line_number;
  assign tokens.start_column = head.start_column;
  assign tokens.token_length = head.token_length;
  assign tokens.error_count  = head.error_count;
  assign tokens.last         = head.last;

endmodule

// File: hdl/source_token_scanner.sv
// channel  dir  payload                                          beats per item
// chars    in   mode, character                                  one
// tokens   out  token_kind, line_number, start_column,           zero to two
//               token_length, error_count, last
//
// one character beat is taken per cycle while the queue has room; the scan state
// decides it in the same cycle; the resulting tokens land in a two-entry output queue
// an item giving two tokens fills the queue: chars.ready drops until the first has left
// chars.ready follows queue room, so a stall on tokens holds back chars
// rst is synchronous and clears the scan state, line to one and the counts to zero
module source_token_scanner
  import sts_pkg::*;
#(
  parameter int LINE_MAX         = 256,
  parameter int LINE_NUMBER_BITS = 16,
  parameter int ERROR_COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  sts_in_if.sink    chars,
  sts_out_if.source tokens
);

  push_t         push;
  queue_status_t q_status;
  logic          fire;

  assign chars.ready = q_status.room;
  assign fire        = chars.valid && q_status.room;

  sts_scan_core #(
    .LINE_MAX         (LINE_MAX),
    .LINE_NUMBER_BITS (LINE_NUMBER_BITS),
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (chars.mode),
    .character (chars.character),
    .push      (push)
  );

  sts_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .tokens (tokens),
    .status (q_status)
  );

`include "source_token_scanner_macros.svh"

  // a token that is not the last of its item has its partner queued behind it
  `STS_ASSERT_NOW(a_pair_queued, clk, rst, tokens.valid && !tokens.last, q_status.fill == 2'd2, "non-last token without partner")

  // restart and the none mode give no token
  `STS_ASSERT_NEXT(a_restart_quiet, clk, rst, fire && (chars.mode == MODE_RESTART || chars.mode == MODE_NONE), !tokens.valid, "token after restart or idle mode")

  // tokens only come from an accepted beat
  `STS_ASSERT_NOW(a_push_on_fire, clk, rst, !fire, push.count == 2'd0, "token pushed without accepted beat")

endmodule
